[hdl/rne_pkg.sv]
// Shared types, constants and lookup functions for the Roman numeral encoder.
// Used by rne_rom, rne_seq, rne_dp and roman_numeral_encoder_core.
package rne_pkg;

  localparam int VALUE_W       = 12;
  localparam int SYMBOL_W      = 7;
  localparam int STATUS_W      = 2;
  localparam int DIGIT_W       = 4;
  localparam int PC_W          = 4;
  localparam int IDX_W         = 3;
  localparam int LEN_W         = 5;
  localparam int MULT_W        = 14;
  localparam int MAX_VALUE_DEF = 3000;
  localparam int RESULT_LIMIT  = 14;

  localparam logic [SYMBOL_W-1:0] CH_NONE = 7'h00;
  localparam logic [SYMBOL_W-1:0] CH_M    = 7'h4D;
  localparam logic [SYMBOL_W-1:0] CH_D    = 7'h44;
  localparam logic [SYMBOL_W-1:0] CH_C    = 7'h43;
  localparam logic [SYMBOL_W-1:0] CH_L    = 7'h4C;
  localparam logic [SYMBOL_W-1:0] CH_X    = 7'h58;
  localparam logic [SYMBOL_W-1:0] CH_V    = 7'h56;
  localparam logic [SYMBOL_W-1:0] CH_I    = 7'h49;

  // Places: thousands, hundreds, tens, ones
  localparam logic [1:0] PL_THOU = 2'd0;
  localparam logic [1:0] PL_HUND = 2'd1;
  localparam logic [1:0] PL_TENS = 2'd2;
  localparam logic [1:0] PL_ONES = 2'd3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIGIT,
    OP_EMIT,
    OP_FLAG
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NOIN,
    CND_ZERO,
    CND_OVER,
    CND_LONG,
    CND_MORE
  } cond_t;

  typedef enum logic [1:0] {
    SLOT_ONE,
    SLOT_FIVE,
    SLOT_TEN,
    SLOT_END
  } slot_t;

  typedef struct packed {
    op_t             op;
    logic [1:0]      place;
    status_t         status;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic zero;
    logic over;
    logic too_long;
    logic more;
    logic stall;
  } flags_t;

  // Symbol slot i of the pattern for digit d.
  function automatic slot_t digit_shape(input logic [DIGIT_W-1:0] d, input logic [IDX_W-1:0] i);
    slot_t s;
    s = SLOT_END;
    unique case (d)
      4'd1:    s = (i == 3'd0) ? SLOT_ONE : SLOT_END;
      4'd2:    s = (i < 3'd2) ? SLOT_ONE : SLOT_END;
      4'd3:    s = (i < 3'd3) ? SLOT_ONE : SLOT_END;
      4'd4:    s = (i == 3'd0) ? SLOT_ONE : ((i == 3'd1) ? SLOT_FIVE : SLOT_END);
      4'd5:    s = (i == 3'd0) ? SLOT_FIVE : SLOT_END;
      4'd6:    s = (i == 3'd0) ? SLOT_FIVE : ((i < 3'd2) ? SLOT_ONE : SLOT_END);
      4'd7:    s = (i == 3'd0) ? SLOT_FIVE : ((i < 3'd3) ? SLOT_ONE : SLOT_END);
      4'd8:    s = (i == 3'd0) ? SLOT_FIVE : ((i < 3'd4) ? SLOT_ONE : SLOT_END);
      4'd9:    s = (i == 3'd0) ? SLOT_ONE : ((i == 3'd1) ? SLOT_TEN : SLOT_END);
      default: s = SLOT_END;
    endcase
    return s;
  endfunction

  // Character count of a digit pattern.
  function automatic logic [2:0] digit_len(input logic [DIGIT_W-1:0] d);
    logic [2:0] n;
    n = 3'd0;
    unique case (d)
      4'd1, 4'd5:       n = 3'd1;
      4'd2, 4'd4, 4'd6,
      4'd9:             n = 3'd2;
      4'd3, 4'd7:       n = 3'd3;
      4'd8:             n = 3'd4;
      default:          n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [SYMBOL_W-1:0] place_symbol(input logic [1:0] p, input slot_t s);
    logic [SYMBOL_W-1:0] c;
    c = CH_NONE;
    unique case (p)
      PL_THOU: c = (s == SLOT_END) ? CH_NONE : CH_M;
      PL_HUND: c = (s == SLOT_ONE) ? CH_C : (s == SLOT_FIVE) ? CH_D :
                   (s == SLOT_TEN) ? CH_M : CH_NONE;
      PL_TENS: c = (s == SLOT_ONE) ? CH_X : (s == SLOT_FIVE) ? CH_L :
                   (s == SLOT_TEN) ? CH_C : CH_NONE;
      PL_ONES: c = (s == SLOT_ONE) ? CH_I : (s == SLOT_FIVE) ? CH_V :
                   (s == SLOT_TEN) ? CH_X : CH_NONE;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

  // k times the weight of place p (ones place weight treated as 1).
  function automatic logic [MULT_W-1:0] place_mult(input logic [1:0] p, input logic [DIGIT_W-1:0] k);
    logic [MULT_W-1:0] m;
    m = '0;
    unique case (p)
      PL_THOU: m = MULT_W'(k) * MULT_W'(1000);
      PL_HUND: m = MULT_W'(k) * MULT_W'(100);
      PL_TENS: m = MULT_W'(k) * MULT_W'(10);
      PL_ONES: m = MULT_W'(k);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

[hdl/rne_rom.sv]
// Microprogram ROM: one control word per step.
// Depends on rne_pkg.
module rne_rom
  import rne_pkg::*;
(
  input  logic [PC_W-1:0] pc,
  output ctrl_t           ctrl
);

  function automatic ctrl_t cw(input op_t op, input logic [1:0] place, input status_t st,
                               input cond_t cond, input logic [PC_W-1:0] target);
    ctrl_t w;
    w.op     = op;
    w.place  = place;
    w.status = st;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  always_comb begin
    unique case (pc)
      4'd0:    ctrl = cw(OP_LOAD,  PL_THOU, ST_OK,    CND_NOIN,   4'd0);
      4'd1:    ctrl = cw(OP_DIGIT, PL_THOU, ST_OK,    CND_ZERO,   4'd11);
      4'd2:    ctrl = cw(OP_DIGIT, PL_HUND, ST_OK,    CND_OVER,   4'd12);
      4'd3:    ctrl = cw(OP_DIGIT, PL_TENS, ST_OK,    CND_NEVER,  4'd0);
      4'd4:    ctrl = cw(OP_NOP,   PL_THOU, ST_OK,    CND_LONG,   4'd12);
      4'd5:    ctrl = cw(OP_EMIT,  PL_THOU, ST_OK,    CND_MORE,   4'd5);
      4'd6:    ctrl = cw(OP_EMIT,  PL_HUND, ST_OK,    CND_MORE,   4'd6);
      4'd7:    ctrl = cw(OP_EMIT,  PL_TENS, ST_OK,    CND_MORE,   4'd7);
      4'd8:    ctrl = cw(OP_EMIT,  PL_ONES, ST_OK,    CND_MORE,   4'd8);
      4'd9:    ctrl = cw(OP_NOP,   PL_THOU, ST_OK,    CND_ALWAYS, 4'd0);
      4'd11:   ctrl = cw(OP_FLAG,  PL_THOU, ST_EMPTY, CND_ALWAYS, 4'd0);
      4'd12:   ctrl = cw(OP_FLAG,  PL_THOU, ST_RANGE, CND_ALWAYS, 4'd0);
      default: ctrl = cw(OP_NOP,   PL_THOU, ST_OK,    CND_ALWAYS, 4'd0);
    endcase
  end

endmodule

[hdl/rne_seq.sv]
// Step counter with conditional jumps, driving the microprogram ROM.
// Depends on rne_pkg and rne_rom.
module rne_seq
  import rne_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  rne_rom u_rom (
    .pc   (pc),
    .ctrl (ctrl)
  );

  always_comb begin
    unique case (ctrl.cond)
      CND_NEVER:  take = 1'b0;
      CND_ALWAYS: take = 1'b1;
      CND_NOIN:   take = !in_valid;
      CND_ZERO:   take = flags.zero;
      CND_OVER:   take = flags.over;
      CND_LONG:   take = flags.too_long;
      CND_MORE:   take = flags.more;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (flags.stall) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = PC_W'(pc + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    flags.stall |=> pc == $past(pc))
    else $error("step counter moved during output stall");

endmodule

[hdl/rne_dp.sv]
// Datapath: digit extraction by parallel compare-subtract, length check,
// pattern emission and the output register.
// Depends on rne_pkg.
module rne_dp
  import rne_pkg::*;
#(
  parameter int MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  output flags_t              flags,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VALUE_W-1:0]  in_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SYMBOL_W-1:0] out_symbol,
  output logic                out_last,
  output status_t             out_status
);

  logic [VALUE_W-1:0] rem;
  logic [DIGIT_W-1:0] dig_th;
  logic [DIGIT_W-1:0] dig_hu;
  logic [DIGIT_W-1:0] dig_te;
  logic [DIGIT_W-1:0] dig_on;
  logic               over;
  logic [IDX_W-1:0]   idx;

  logic [8:0]         ge;
  logic [DIGIT_W-1:0] count;
  logic [VALUE_W-1:0] rem_sub;
  logic [DIGIT_W-1:0] cur_dig;
  logic               lower_zero;
  slot_t              slot;
  slot_t              slot_nxt;
  logic               emitting;
  logic               out_free;
  logic               out_load;
  logic [LEN_W-1:0]   num_len;

  assign dig_on   = rem[DIGIT_W-1:0];
  // no request is taken while reset is held
  assign in_ready = (ctrl.op == OP_LOAD) && !rst;
  assign out_free = !out_valid || out_ready;

  // Digit = number of multiples of the place weight not above the remainder.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      ge[k] = {{(MULT_W-VALUE_W){1'b0}}, rem} >= place_mult(ctrl.place, DIGIT_W'(k + 1));
    end
    count   = DIGIT_W'($countones(ge));
    rem_sub = rem - VALUE_W'(place_mult(ctrl.place, count));
  end

  always_comb begin
    unique case (ctrl.place)
      PL_THOU: begin
        cur_dig    = dig_th;
        lower_zero = (dig_hu == '0) && (dig_te == '0) && (dig_on == '0);
      end
      PL_HUND: begin
        cur_dig    = dig_hu;
        lower_zero = (dig_te == '0) && (dig_on == '0);
      end
      PL_TENS: begin
        cur_dig    = dig_te;
        lower_zero = (dig_on == '0);
      end
      default: begin
        cur_dig    = dig_on;
        lower_zero = 1'b1;
      end
    endcase
  end

  assign slot     = digit_shape(cur_dig, idx);
  assign slot_nxt = digit_shape(cur_dig, IDX_W'(idx + 1'b1));
  assign emitting = (ctrl.op == OP_EMIT) && (slot != SLOT_END);

  assign num_len = LEN_W'(dig_th) + LEN_W'(digit_len(dig_hu)) + LEN_W'(digit_len(dig_te)) +
                   LEN_W'(digit_len(dig_on));

  assign out_load = (emitting || ctrl.op == OP_FLAG) && out_free;

  always_comb begin
    flags.zero     = (rem == '0);
    flags.over     = over;
    flags.too_long = (num_len > LEN_W'(RESULT_LIMIT));
    flags.more     = emitting && (slot_nxt != SLOT_END);
    flags.stall    = (emitting || ctrl.op == OP_FLAG) && !out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emitting && out_load) begin
        idx <= flags.more ? IDX_W'(idx + 1'b1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == OP_LOAD && in_valid) begin
      rem  <= in_value;
      over <= in_value > VALUE_W'(MAX_VALUE);
    end else if (ctrl.op == OP_DIGIT) begin
      rem <= rem_sub;
      unique case (ctrl.place)
        PL_THOU: dig_th <= count;
        PL_HUND: dig_hu <= count;
        default: dig_te <= count;
      endcase
    end
    if (out_load) begin
      if (ctrl.op == OP_FLAG) begin
        out_symbol <= CH_NONE;
        out_last   <= 1'b1;
        out_status <= ctrl.status;
      end else begin
        out_symbol <= place_symbol(ctrl.place, slot);
        out_last   <= lower_zero && (slot_nxt == SLOT_END);
        out_status <= ST_OK;
      end
    end
  end

  a_ones_digit: assert property (@(posedge clk) disable iff (rst)
    ctrl.op == OP_EMIT |-> rem < VALUE_W'(10))
    else $error("ones remainder not a single digit while emitting");

  a_ok_has_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == ST_OK |-> out_symbol != CH_NONE)
    else $error("character result without a character");

  a_flag_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("status result not marked last");

endmodule

[hdl/roman_numeral_encoder_core.sv]
// Roman numeral encoder: one 12-bit value in, its numeral out as ASCII
// characters, most significant first, one per output request, tlast on the
// final one. Zero gives a single empty-status request, values above
// MAX_VALUE (or numerals over fourteen characters) a single out-of-range one.
// A small microprogram steps a compare-subtract datapath: a load step, a
// digit-extraction step for each of thousands, hundreds and tens, a length
// check, then one character per cycle for each nonzero place while the
// output register is not held by backpressure (an idle step per zero place)
// and a return step. Empty values leave after the thousands step, values
// above MAX_VALUE after the hundreds step, and numerals over fourteen
// characters after the length check, each to a single status request.
// One value is in flight at a time; the next is taken on the load step.
// Depends on rne_pkg, rne_seq, rne_rom and rne_dp.
module roman_numeral_encoder_core
  import rne_pkg::*;
#(
  parameter int MAX_VALUE = MAX_VALUE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [11:0] value, [15:12] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] symbol, [7] zero
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // [1:0] status
);

  ctrl_t               ctrl;
  flags_t              flags;
  logic [SYMBOL_W-1:0] symbol;
  status_t             status;

  rne_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .flags    (flags),
    .ctrl     (ctrl)
  );

  rne_dp #(
    .MAX_VALUE (MAX_VALUE)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .flags      (flags),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_value   (s_tdata[VALUE_W-1:0]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_symbol (symbol),
    .out_last   (m_tlast),
    .out_status (status)
  );

  assign m_tdata = {1'b0, symbol};
  assign m_tuser = status;

endmodule
